### rtl/ivm_pkg.sv
package ivm_pkg;

    localparam int GRAD_WIDTH_DEF = 32;

    localparam int STRESS_W  = 48;
    localparam int STRESS_SH = 16;
    localparam int VM_W      = 48;

    // magnitudes are split into a high and a low part for squaring
    localparam int MAG_W   = STRESS_W + 1;
    localparam int SPLIT_L = 25;
    localparam int SPLIT_H = MAG_W - SPLIT_L;
    localparam int SQ_W    = 2 * MAG_W;

    // radicand of the root and root width
    localparam int RAD_W  = 102;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MODULUS = 4'd2;

    localparam logic [1:0] MODE_KEEP_ALL   = 2'd0;
    localparam logic [1:0] MODE_DROP_DISP  = 2'd1;
    localparam logic [1:0] MODE_DROP_FORCE = 2'd2;

    localparam logic signed [STRESS_W-1:0] STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
    localparam logic signed [STRESS_W-1:0] STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

endpackage

### rtl/isotropic_stress_von_mises.sv
// Throughput: one particle per cycle; the whole pipeline holds on an output stall.
// The square root takes one bit per stage over 51 stages and sets the latency.
// Dropped particles leave a bubble and produce no output beat.
// Reset (synchronous, active low) clears all valid bits and config registers to 0.
module isotropic_stress_von_mises #(
    parameter int GRAD_WIDTH = ivm_pkg::GRAD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ivm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ivm_pkg::CFG_DAT_W-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_ux_x,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_ux_y,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_ux_z,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uy_x,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uy_y,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uy_z,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uz_x,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uz_y,
    input  logic signed [GRAD_WIDTH-1:0]           i_grad_uz_z,
    input  logic                                   i_disp_constrained,
    input  logic                                   i_force_applied,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [GRAD_WIDTH-1:0]           o_shear_strain_xy,
    output logic signed [GRAD_WIDTH-1:0]           o_shear_strain_xz,
    output logic signed [GRAD_WIDTH-1:0]           o_shear_strain_yz,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_xx,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_yy,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_zz,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_xy,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_xz,
    output logic signed [ivm_pkg::STRESS_W-1:0]    o_stress_yz,
    output logic [ivm_pkg::VM_W-1:0]               o_von_mises
);

    localparam int G    = GRAD_WIDTH;
    localparam int SW_  = ivm_pkg::STRESS_W;
    localparam int TR_W = G + 2;
    localparam int MW   = G + 36;                  // product sum width, 32 fraction bits
    localparam int SHW  = (MW - ivm_pkg::STRESS_SH > SW_) ? MW - ivm_pkg::STRESS_SH : SW_ + 1;
    localparam int PAY_W = 3 * G + 6 * SW_;
    localparam int MAG_W = ivm_pkg::MAG_W;
    localparam int SL    = ivm_pkg::SPLIT_L;
    localparam int SH    = ivm_pkg::SPLIT_H;
    localparam int SQ_W  = ivm_pkg::SQ_W;
    localparam int RAD_W = ivm_pkg::RAD_W;
    localparam int ROOT_W = ivm_pkg::ROOT_W;
    localparam int REM_W = ivm_pkg::REM_W;
    localparam int ACC_W = SQ_W + 2;

    // ---------------- configuration ----------------
    logic [1:0]  r_mode;
    logic [31:0] r_lambda;
    logic [31:0] r_mu;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ivm_pkg::MODE_KEEP_ALL;
            r_lambda <= '0;
            r_mu     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ivm_pkg::REG_FILTER_MODE:   r_mode   <= i_cfg_data[1:0];
                ivm_pkg::REG_LAME_LAMBDA:   r_lambda <= i_cfg_data;
                ivm_pkg::REG_SHEAR_MODULUS: r_mu     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; the last stage is the output register
    logic w_adv;
    logic r_out_vld;
    assign w_adv      = !r_out_vld || i_out_ready;
    assign o_in_ready = w_adv;
    assign o_out_valid = r_out_vld;

    logic w_keep;
    always_comb begin
        w_keep = 1'b1;
        if (r_mode != ivm_pkg::MODE_KEEP_ALL && i_disp_constrained)
            w_keep = 1'b0;
        // the unused mode code acts like the force drop mode
        if (r_mode >= ivm_pkg::MODE_DROP_FORCE && i_force_applied)
            w_keep = 1'b0;
    end

    // ---------------- stage 1: shear strains and trace ----------------
    logic signed [G:0]      w_sxy, w_sxz, w_syz;
    logic signed [TR_W-1:0] w_tr;
    assign w_sxy = (G+1)'(i_grad_ux_y) + (G+1)'(i_grad_uy_x);
    assign w_sxz = (G+1)'(i_grad_ux_z) + (G+1)'(i_grad_uz_x);
    assign w_syz = (G+1)'(i_grad_uy_z) + (G+1)'(i_grad_uz_y);
    assign w_tr  = TR_W'(i_grad_ux_x) + TR_W'(i_grad_uy_y) + TR_W'(i_grad_uz_z);

    logic                   r1_vld;
    logic signed [G-1:0]    r1_gx, r1_gy, r1_gz, r1_exy, r1_exz, r1_eyz;
    logic signed [TR_W-1:0] r1_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_gx  <= i_grad_ux_x;
            r1_gy  <= i_grad_uy_y;
            r1_gz  <= i_grad_uz_z;
            r1_exy <= w_sxy[G:1];          // floor half
            r1_exz <= w_sxz[G:1];
            r1_eyz <= w_syz[G:1];
            r1_tr  <= w_tr;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [MW-1:0] w_lam, w_tmu;
    logic signed [MW-1:0] w_op [6];
    assign w_lam = MW'(signed'({1'b0, r_lambda}));
    assign w_tmu = MW'(signed'({2'b00, r_mu, 1'b0}));
    assign w_op[0] = MW'(r1_gx);
    assign w_op[1] = MW'(r1_gy);
    assign w_op[2] = MW'(r1_gz);
    assign w_op[3] = MW'(r1_exy);
    assign w_op[4] = MW'(r1_exz);
    assign w_op[5] = MW'(r1_eyz);

    logic                 r2_vld;
    logic signed [MW-1:0] r2_lt;
    logic signed [MW-1:0] r2_p [6];
    logic signed [G-1:0]  r2_exy, r2_exz, r2_eyz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_lt  <= MW'(r1_tr) * w_lam;
            for (int i = 0; i < 6; i++) begin
                r2_p[i] <= w_op[i] * w_tmu;
            end
            r2_exy <= r1_exy;
            r2_exz <= r1_exz;
            r2_eyz <= r1_eyz;
        end
    end

    // ---------------- stage 3: Hooke sums, floor shift, saturate ----------------
    function automatic logic signed [SW_-1:0] f_sat(input logic signed [MW-1:0] v);
        logic signed [SHW-1:0] sh;
        logic [SHW-SW_:0]      top;
        sh  = SHW'(v >>> ivm_pkg::STRESS_SH);
        top = sh[SHW-1:SW_-1];
        if ((&top) || !(|top))
            f_sat = sh[SW_-1:0];
        else if (sh[SHW-1])
            f_sat = ivm_pkg::STRESS_MIN;
        else
            f_sat = ivm_pkg::STRESS_MAX;
    endfunction

    logic signed [MW-1:0] w_sum [6];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = r2_lt + r2_p[i];
        end
        for (int i = 3; i < 6; i++) begin
            w_sum[i] = r2_p[i];
        end
    end

    logic                  r3_vld;
    logic signed [SW_-1:0] r3_st [6];
    logic [3*G-1:0]        r3_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 6; i++) begin
                r3_st[i] <= f_sat(w_sum[i]);
            end
            r3_e <= {r2_exy, r2_exz, r2_eyz};
        end
    end

    logic [PAY_W-1:0] w_pay3;
    assign w_pay3 = {r3_e, r3_st[0], r3_st[1], r3_st[2], r3_st[3], r3_st[4], r3_st[5]};

    // ---------------- stage 4: magnitudes ----------------
    logic signed [MAG_W-1:0] w_d [6];
    logic [MAG_W-1:0]        w_m [6];
    always_comb begin
        w_d[0] = MAG_W'(r3_st[0]) - MAG_W'(r3_st[1]);
        w_d[1] = MAG_W'(r3_st[1]) - MAG_W'(r3_st[2]);
        w_d[2] = MAG_W'(r3_st[2]) - MAG_W'(r3_st[0]);
        w_d[3] = MAG_W'(r3_st[3]);
        w_d[4] = MAG_W'(r3_st[4]);
        w_d[5] = MAG_W'(r3_st[5]);
        for (int i = 0; i < 6; i++) begin
            w_m[i] = w_d[i][MAG_W-1] ? MAG_W'(-w_d[i]) : MAG_W'(w_d[i]);
        end
    end

    logic             r4_vld;
    logic [MAG_W-1:0] r4_m [6];
    logic [PAY_W-1:0] r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_m   <= w_m;
            r4_pay <= w_pay3;
        end
    end

    // ---------------- stage 5: partial products of the squares ----------------
    logic                r5_vld;
    logic [2*SH-1:0]     r5_hh [6];
    logic [SH+SL-1:0]    r5_hl [6];
    logic [2*SL-1:0]     r5_ll [6];
    logic [PAY_W-1:0]    r5_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 6; i++) begin
                r5_hh[i] <= (2*SH)'(r4_m[i][MAG_W-1:SL]) * (2*SH)'(r4_m[i][MAG_W-1:SL]);
                r5_hl[i] <= (SH+SL)'(r4_m[i][MAG_W-1:SL]) * (SH+SL)'(r4_m[i][SL-1:0]);
                r5_ll[i] <= (2*SL)'(r4_m[i][SL-1:0]) * (2*SL)'(r4_m[i][SL-1:0]);
            end
            r5_pay <= r4_pay;
        end
    end

    // ---------------- stage 6: squares ----------------
    logic            r6_vld;
    logic [SQ_W-1:0] r6_sq [6];
    logic [PAY_W-1:0] r6_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_adv) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 6; i++) begin
                r6_sq[i] <= (SQ_W'(r5_hh[i]) << (2*SL))
                          + (SQ_W'(r5_hl[i]) << (SL+1))
                          + SQ_W'(r5_ll[i]);
            end
            r6_pay <= r5_pay;
        end
    end

    // ---------------- stage 7: partial sums ----------------
    logic             r7_vld;
    logic [ACC_W-1:0] r7_a, r7_b;
    logic [PAY_W-1:0] r7_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_a   <= ACC_W'(r6_sq[0]) + ACC_W'(r6_sq[1]) + ACC_W'(r6_sq[2]);
            r7_b   <= ACC_W'(r6_sq[3]) + ACC_W'(r6_sq[4]) + ACC_W'(r6_sq[5]);
            r7_pay <= r6_pay;
        end
    end

    // ---------------- stage 8: radicand, then root stages ----------------
    logic [RAD_W:0] w_q;
    assign w_q = (RAD_W+1)'(r7_a) + ((RAD_W+1)'(r7_b) << 2) + ((RAD_W+1)'(r7_b) << 1);

    logic              r_sv   [ROOT_W+1];
    logic [RAD_W-1:0]  r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic [PAY_W-1:0]  r_sp   [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rad[0]  <= w_q[RAD_W:1];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sp[0]   <= r7_pay;
        end
    end

    // one root bit per stage: bring down two radicand bits, trial subtract
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0] w_r2, w_t;
        logic             w_ge;
        assign w_r2 = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1:RAD_W-2]};
        assign w_t  = {r_root[k], 2'b01};
        assign w_ge = (w_r2 >= w_t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rad[k+1]  <= {r_rad[k][RAD_W-3:0], 2'b00};
                r_rem[k+1]  <= w_ge ? w_r2 - w_t : w_r2;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], w_ge};
                r_sp[k+1]   <= r_sp[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic [ivm_pkg::VM_W-1:0] w_vm;
    assign w_vm = (|r_root[ROOT_W][ROOT_W-1:ivm_pkg::VM_W]) ? '1
                                                            : r_root[ROOT_W][ivm_pkg::VM_W-1:0];

    logic [PAY_W-1:0]         r_out_pay;
    logic [ivm_pkg::VM_W-1:0] r_out_vm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pay <= r_sp[ROOT_W];
            r_out_vm  <= w_vm;
        end
    end

    assign o_shear_strain_xy = r_out_pay[PAY_W-1 -: G];
    assign o_shear_strain_xz = r_out_pay[PAY_W-1-G -: G];
    assign o_shear_strain_yz = r_out_pay[PAY_W-1-2*G -: G];
    assign o_stress_xx       = r_out_pay[6*SW_-1 -: SW_];
    assign o_stress_yy       = r_out_pay[5*SW_-1 -: SW_];
    assign o_stress_zz       = r_out_pay[4*SW_-1 -: SW_];
    assign o_stress_xy       = r_out_pay[3*SW_-1 -: SW_];
    assign o_stress_xz       = r_out_pay[2*SW_-1 -: SW_];
    assign o_stress_yz       = r_out_pay[SW_-1 -: SW_];
    assign o_von_mises       = r_out_vm;

endmodule

### rtl/ivm_chk.sv
module ivm_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_xx,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_yy,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_zz,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_xy,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_xz,
    input logic signed [ivm_pkg::STRESS_W-1:0] o_stress_yz,
    input logic [ivm_pkg::VM_W-1:0]            o_von_mises
);

    // input side is held exactly when an output beat is stuck
    a_ready_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_von_mises) && $stable(o_stress_xx))
        else $error("output beat changed while stalled");

    // zero stress tensor must give zero equivalent stress
    a_vm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stress_xx == 0 && o_stress_yy == 0 && o_stress_zz == 0
            && o_stress_xy == 0 && o_stress_xz == 0 && o_stress_yz == 0
        |-> o_von_mises == 0)
        else $error("nonzero von Mises for zero stress");

endmodule

bind isotropic_stress_von_mises ivm_chk u_ivm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_stress_xx (o_stress_xx),
    .o_stress_yy (o_stress_yy),
    .o_stress_zz (o_stress_zz),
    .o_stress_xy (o_stress_xy),
    .o_stress_xz (o_stress_xz),
    .o_stress_yz (o_stress_yz),
    .o_von_mises (o_von_mises)
);
